### rtl/ipa_pkg.sv
// ipa_pkg: shared types, constants and a helper function of the id pool allocator
// used by every module under rtl/, depends on nothing

package ipa_pkg;

  // built pool capacity and field widths
  localparam int Capacity = 1024;
  localparam int IdW      = 10;
  localparam int CntW     = 11;
  localparam int ActW     = 2;

  // released map organised as words of bits, one summary bit per word
  localparam int WordW  = 32;
  localparam int Words  = Capacity / WordW;
  localparam int WordAW = $clog2(Words);
  localparam int BitAW  = $clog2(WordW);

  // request queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [ActW-1:0] {
    ACT_GET     = 2'd0,
    ACT_CHECK   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_IGNORE  = 2'd3
  } action_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  // one classified request as it travels through the queue
  typedef struct packed {
    action_e        act;
    logic [IdW-1:0] number;
  } ipa_req_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } ipa_qstat_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BitAW-1:0] lowest_set(input logic [WordW-1:0] v);
    logic [BitAW-1:0] r;
    r = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) r = BitAW'(i);
    end
    return r;
  endfunction

endpackage

### rtl/ipa_front.sv
// ipa_front: accepts requests and classifies them by action
// depends on ipa_pkg; feeds ipa_queue

module ipa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ipa_pkg::ActW-1:0] action_i,
  input  logic [ipa_pkg::IdW-1:0]  number_i,
  input  ipa_pkg::ipa_qstat_t      qstat_i,
  output logic                     push_o,
  output ipa_pkg::ipa_req_t        req_o
);

  logic accept;
  logic seen_q;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // unknown action is swallowed here and never reaches the back
  assign push_o     = accept && (ipa_pkg::action_e'(action_i) != ipa_pkg::ACT_IGNORE);
  assign req_o.act    = ipa_pkg::action_e'(action_i);
  assign req_o.number = number_i;

  // tracks that at least one request has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (accept) begin
      seen_q <= 1'b1;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_i.full |-> !push_o)
    else $error("push while queue full");
  a_ignore_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ipa_pkg::ACT_IGNORE) |-> !push_o)
    else $error("ignored action pushed");
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_valid_i && !seen_q) || (in_valid_i && seen_q))
    else $error("push without request");

endmodule

### rtl/ipa_queue.sv
// ipa_queue: short request queue between front and back
// depends on ipa_pkg

module ipa_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ipa_pkg::ipa_req_t   req_i,
  output ipa_pkg::ipa_qstat_t qstat_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ipa_pkg::ipa_req_t   req_o
);

  ipa_pkg::ipa_req_t               mem_q [ipa_pkg::QueueDepth];
  logic [ipa_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ipa_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ipa_pkg::QCntW-1:0]       count_q, count_d;
  logic                            do_push, do_pop;

  localparam logic [ipa_pkg::QPtrW-1:0] LastPtr = ipa_pkg::QPtrW'(ipa_pkg::QueueDepth - 1);
  localparam logic [ipa_pkg::QCntW-1:0] FullCnt = ipa_pkg::QCntW'(ipa_pkg::QueueDepth);

  assign qstat_o.full  = (count_q == FullCnt);
  assign qstat_o.empty = (count_q == '0);
  assign valid_o       = !qstat_o.empty;
  assign req_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow");
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not shrink");

endmodule

### rtl/ipa_back.sv
// ipa_back: carries out get, check and release against the released map
// depends on ipa_pkg; takes requests from ipa_queue, drives the result register

module ipa_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ipa_pkg::CntW-1:0] limit_i,
  input  logic                     q_valid_i,
  input  ipa_pkg::ipa_req_t        q_req_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ipa_pkg::IdW-1:0]  granted_id_o,
  output logic                     ok_o
);

  // released map memory and its per-word summary (also the valid bits)
  logic [ipa_pkg::WordW-1:0]  map_mem [ipa_pkg::Words];
  logic [ipa_pkg::WordW-1:0]  rdata_q;
  logic [ipa_pkg::Words-1:0]  summary_q, summary_d;

  ipa_pkg::back_state_e       state_q, state_d;
  ipa_pkg::action_e           act_q, act_d;
  logic [ipa_pkg::IdW-1:0]    number_q, number_d;
  logic [ipa_pkg::WordAW-1:0] widx_q, widx_d;
  logic [ipa_pkg::CntW-1:0]   next_fresh_q, next_fresh_d;

  logic                       out_valid_q, out_valid_d;
  logic [ipa_pkg::IdW-1:0]    granted_q, granted_d;
  logic                       ok_q, ok_d;

  logic                       rd_en;
  logic [ipa_pkg::WordAW-1:0] rd_addr;
  logic                       wr_en;
  logic [ipa_pkg::WordW-1:0]  wr_data;

  logic [ipa_pkg::WordW-1:0]  word;
  logic [ipa_pkg::BitAW-1:0]  low_bit;
  logic [ipa_pkg::BitAW-1:0]  num_bit;
  logic [ipa_pkg::CntW-1:0]   number_ext;
  logic                       out_free;
  logic                       needs_out;

  assign word       = summary_q[widx_q] ? rdata_q : '0;
  assign low_bit    = ipa_pkg::lowest_set(word);
  assign num_bit    = number_q[ipa_pkg::BitAW-1:0];
  assign number_ext = ipa_pkg::CntW'(number_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign needs_out  = (act_q == ipa_pkg::ACT_GET) || (act_q == ipa_pkg::ACT_CHECK);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    number_d     = number_q;
    widx_d       = widx_q;
    next_fresh_d = next_fresh_q;
    summary_d    = summary_q;
    out_valid_d  = out_valid_q && out_stall_i;
    granted_d    = granted_q;
    ok_d         = ok_q;
    q_pop_o      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_data      = word;

    case (state_q)
      ipa_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          rd_en    = 1'b1;
          // a get reads the lowest word that holds a released id
          rd_addr  = (q_req_i.act == ipa_pkg::ACT_GET) ?
                     ipa_pkg::WordAW'(ipa_pkg::lowest_set(ipa_pkg::WordW'(summary_q))) :
                     q_req_i.number[ipa_pkg::IdW-1:ipa_pkg::BitAW];
          act_d    = q_req_i.act;
          number_d = q_req_i.number;
          widx_d   = rd_addr;
          state_d  = ipa_pkg::BK_EXEC;
        end
      end
      ipa_pkg::BK_EXEC: begin
        if (!needs_out || out_free) begin
          state_d = ipa_pkg::BK_IDLE;
          case (act_q)
            ipa_pkg::ACT_GET: begin
              out_valid_d = 1'b1;
              granted_d   = '0;
              ok_d        = 1'b0;
              if (summary_q != '0) begin
                wr_en             = 1'b1;
                wr_data           = word & ~(ipa_pkg::WordW'(1) << low_bit);
                summary_d[widx_q] = |wr_data;
                granted_d         = {widx_q, low_bit};
                ok_d              = 1'b1;
              end else if (next_fresh_q < limit_i) begin
                granted_d    = next_fresh_q[ipa_pkg::IdW-1:0];
                next_fresh_d = next_fresh_q + 1'b1;
                ok_d         = 1'b1;
              end
            end
            ipa_pkg::ACT_CHECK: begin
              out_valid_d = 1'b1;
              granted_d   = '0;
              if (number_ext >= limit_i) begin
                ok_d = 1'b0;
              end else if (number_ext >= next_fresh_q) begin
                ok_d = 1'b1;
              end else begin
                ok_d = word[num_bit];
              end
            end
            ipa_pkg::ACT_RELEASE: begin
              if (number_ext < next_fresh_q) begin
                wr_en             = 1'b1;
                wr_data           = word | (ipa_pkg::WordW'(1) << num_bit);
                summary_d[widx_q] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ipa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ipa_pkg::BK_IDLE;
      act_q        <= ipa_pkg::ACT_GET;
      number_q     <= '0;
      widx_q       <= '0;
      next_fresh_q <= '0;
      summary_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      act_q        <= act_d;
      number_q     <= number_d;
      widx_q       <= widx_d;
      next_fresh_q <= next_fresh_d;
      summary_q    <= summary_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    ok_q      <= ok_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[widx_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign ok_o         = ok_q;

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_fresh_q <= ipa_pkg::CntW'(ipa_pkg::Capacity))
    else $error("fresh watermark beyond capacity");
  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> granted_q == '0)
    else $error("failed request carries an id");
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ipa_pkg::BK_EXEC)
    else $error("result appeared outside execute");
  a_idle_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipa_pkg::BK_IDLE && q_valid_i) |=> state_q == ipa_pkg::BK_EXEC)
    else $error("request not taken into execute");
  a_no_read_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipa_pkg::BK_EXEC) |-> !rd_en && !q_pop_o)
    else $error("map read while executing");

endmodule

### rtl/id_pool_allocator.sv
// id_pool_allocator: top level of the id pool allocator
// depends on ipa_pkg, ipa_front, ipa_queue and ipa_back

// Hands out 10-bit ids from a pool of min(max_numbers, 1024) entries. Each request
// is a get (grants the lowest released id, else the next never-used id, else
// reports an empty pool with ok low), a check (ok high if the id is free) or a
// release (returns an id below the fresh watermark; no result). Action 3 is
// dropped with no result. The back end reads the 32-bit released-map word with a
// registered read in its idle state and does the update and write-back in its execute
// state, taking no new request until it is through with the last; the front keeps
// accepting into a two-deep queue while a result waits in the output register.
// The released map is a 32 x 32 memory with one summary bit per word that reset
// clears, so the map is empty straight after reset with no clearing pass.
// max_numbers is written through the cfg port, always ready, and must only be
// written while no request is in flight.

module id_pool_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ipa_pkg::ActW-1:0] action_i,
  input  logic [ipa_pkg::IdW-1:0]  number_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ipa_pkg::IdW-1:0]  granted_id_o,
  output logic                     ok_o,
  // configuration write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ipa_pkg::CntW-1:0] cfg_max_numbers_i
);

  logic [ipa_pkg::CntW-1:0] max_numbers_q;
  logic [ipa_pkg::CntW-1:0] limit;

  ipa_pkg::ipa_qstat_t qstat;
  ipa_pkg::ipa_req_t   push_req;
  ipa_pkg::ipa_req_t   head_req;
  logic                push;
  logic                head_valid;
  logic                pop;

  // pool size register, write taken in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_numbers_q <= ipa_pkg::CntW'(ipa_pkg::Capacity);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_numbers_q <= cfg_max_numbers_i;
    end
  end

  // effective pool size, clipped to the built capacity
  assign limit = (max_numbers_q > ipa_pkg::CntW'(ipa_pkg::Capacity)) ?
                 ipa_pkg::CntW'(ipa_pkg::Capacity) : max_numbers_q;

  // front: accept and classify
  ipa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .number_i   (number_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .req_o      (push_req)
  );

  // decoupling queue
  ipa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .qstat_o (qstat),
    .pop_i   (pop),
    .valid_o (head_valid),
    .req_o   (head_req)
  );

  // back: map read, update and result register
  ipa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .q_valid_i    (head_valid),
    .q_req_i      (head_req),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .granted_id_o (granted_id_o),
    .ok_o         (ok_o)
  );

  a_limit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit <= ipa_pkg::CntW'(ipa_pkg::Capacity))
    else $error("pool size beyond capacity");
  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> max_numbers_q == $past(cfg_max_numbers_i))
    else $error("pool size write lost");
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> in_stall_o)
    else $error("request taken into full queue");

endmodule
